### rtl/dia_pkg.sv
// ----------------------------------------------------------------------------
// dia_pkg
// Types, opcodes and helpers shared by the dual interval ALU.
// ----------------------------------------------------------------------------
package dia_pkg;

  localparam int W  = 32;
  localparam int PW = 2 * W;

  localparam int IN_TDATA_W  = 264;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 136;

  localparam int FLG_EMPTY = 0;
  localparam int FLG_STOP  = 1;
  localparam int FLG_UTOP  = 2;

  typedef logic [W-1:0]  word_t;
  typedef logic [PW-1:0] prod_t;

  localparam word_t SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_UDIV = 3'd3,
    OP_SDIV = 3'd4,
    OP_JOIN = 3'd5,
    OP_TOP  = 3'd6
  } op_t;

  typedef struct packed {
    logic  empty;
    logic  stop;
    logic  utop;
    word_t slo;
    word_t shi;
    word_t ulo;
    word_t uhi;
  } ival_t;

  // front end to back end, one request
  typedef struct packed {
    op_t             op;
    ival_t           early;
    logic [3:0]      sneg;
    logic [3:0][W-1:0] sv;
    logic            sov;
    logic [3:0][W-1:0] uv;
    logic            uov;
  } side_t;

  function automatic logic is_neg(input word_t x);
    return x[W-1];
  endfunction

  function automatic word_t mag(input word_t x);
    return x[W-1] ? word_t'(-x) : x;
  endfunction

  function automatic logic s_lt(input word_t x, input word_t y);
    return (x ^ SMIN) < (y ^ SMIN);
  endfunction

  function automatic word_t lim(input logic neg);
    return neg ? SMIN : word_t'(SMIN - word_t'(1));
  endfunction

endpackage

### rtl/dia_div.sv
// ----------------------------------------------------------------------------
// dia_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module dia_div (
  input  logic           clk,
  input  logic           en,
  input  dia_pkg::word_t num,
  input  dia_pkg::word_t den,
  output dia_pkg::word_t quo
);
  import dia_pkg::*;

  word_t          rem_r [W-1];
  word_t          den_r [W-1];
  word_t          quo_r [W];
  word_t          r_in  [W];
  word_t          q_in  [W];
  word_t          d_in  [W];
  logic [W:0]     shf   [W];
  logic [W+1:0]   trl   [W];

  always_comb begin
    for (int k = 0; k < W; k++) begin
      if (k == 0) begin
        r_in[k] = '0;
        q_in[k] = num;
        d_in[k] = den;
      end else begin
        r_in[k] = rem_r[k-1];
        q_in[k] = quo_r[k-1];
        d_in[k] = den_r[k-1];
      end
      shf[k] = {r_in[k], q_in[k][W-1]};
      trl[k] = {1'b0, shf[k]} - {2'b00, d_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        quo_r[k] <= {q_in[k][W-2:0], ~trl[k][W+1]};
        if (k < W - 1) begin
          rem_r[k] <= trl[k][W+1] ? shf[k][W-1:0] : trl[k][W-1:0];
          den_r[k] <= d_in[k];
        end
      end
    end
  end

  assign quo = quo_r[W-1];

endmodule

### rtl/dia_front.sv
// ----------------------------------------------------------------------------
// dia_front
// Operand decode, add/sub/join/top results, corner products (3 stages).
// ----------------------------------------------------------------------------
module dia_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2:0]                   opcode,
  input  logic [2:0]                   a_flags,
  input  dia_pkg::word_t               a_signed_low,
  input  dia_pkg::word_t               a_signed_high,
  input  dia_pkg::word_t               a_unsigned_low,
  input  dia_pkg::word_t               a_unsigned_high,
  input  logic [2:0]                   b_flags,
  input  dia_pkg::word_t               b_signed_low,
  input  dia_pkg::word_t               b_signed_high,
  input  dia_pkg::word_t               b_unsigned_low,
  input  dia_pkg::word_t               b_unsigned_high,
  output logic [3:0][dia_pkg::W-1:0]   dx,
  output logic [3:0][dia_pkg::W-1:0]   dy,
  output dia_pkg::side_t               side
);
  import dia_pkg::*;

  ival_t a, b, early;
  op_t   op;
  word_t ssum_lo, ssum_hi, sdif_lo, sdif_hi;
  logic [W:0] usum_lo, usum_hi;
  logic  szero, uzero;

  op_t               op1_r, op2_r;
  ival_t             early1_r, early2_r;
  logic [1:0][W-1:0] smx1_r, smy1_r, ux1_r, uy1_r;
  logic [3:0]        sneg1_r, sneg2_r;
  prod_t             sp2_r [4];
  prod_t             up2_r [4];
  side_t             side_nxt, side_r;

  always_comb begin
    op = op_t'(opcode);
    a  = '{a_flags[FLG_EMPTY], a_flags[FLG_STOP], a_flags[FLG_UTOP],
           a_signed_low, a_signed_high, a_unsigned_low, a_unsigned_high};
    b  = '{b_flags[FLG_EMPTY], b_flags[FLG_STOP], b_flags[FLG_UTOP],
           b_signed_low, b_signed_high, b_unsigned_low, b_unsigned_high};

    ssum_lo = a.slo + b.slo;
    ssum_hi = a.shi + b.shi;
    sdif_lo = a.slo - b.shi;
    sdif_hi = a.shi - b.slo;
    usum_lo = {1'b0, a.ulo} + {1'b0, b.ulo};
    usum_hi = {1'b0, a.uhi} + {1'b0, b.uhi};
    uzero   = (b.ulo == '0) || (b.uhi == '0);
    szero   = (b.slo == '0) || (b.shi == '0) || (is_neg(b.slo) && !is_neg(b.shi));

    early = '0;
    if (op == OP_JOIN) begin
      if (a.empty) begin
        early = b;
      end else if (b.empty) begin
        early = a;
      end else begin
        early.stop = a.stop | b.stop;
        early.utop = a.utop | b.utop;
        early.slo  = s_lt(b.slo, a.slo) ? b.slo : a.slo;
        early.shi  = s_lt(a.shi, b.shi) ? b.shi : a.shi;
        early.ulo  = (b.ulo < a.ulo) ? b.ulo : a.ulo;
        early.uhi  = (a.uhi < b.uhi) ? b.uhi : a.uhi;
      end
    end else if (a.empty || b.empty) begin
      early.empty = 1'b1;
    end else begin
      early.stop = a.stop | b.stop;
      early.utop = a.utop | b.utop;
      case (op)
        OP_ADD: begin
          early.slo = ssum_lo;
          early.shi = ssum_hi;
          if ((is_neg(a.slo) == is_neg(b.slo) && is_neg(ssum_lo) != is_neg(a.slo)) ||
              (is_neg(a.shi) == is_neg(b.shi) && is_neg(ssum_hi) != is_neg(a.shi)))
            early.stop = 1'b1;
          early.ulo = usum_lo[W-1:0];
          early.uhi = usum_hi[W-1:0];
          if (usum_lo[W] || usum_hi[W]) early.utop = 1'b1;
        end
        OP_SUB: begin
          early.slo = sdif_lo;
          early.shi = sdif_hi;
          if ((is_neg(a.slo) != is_neg(b.shi) && is_neg(sdif_lo) != is_neg(a.slo)) ||
              (is_neg(a.shi) != is_neg(b.slo) && is_neg(sdif_hi) != is_neg(a.shi)))
            early.stop = 1'b1;
          if (a.ulo < b.uhi || a.uhi < b.ulo) begin
            early.utop = 1'b1;
          end else begin
            early.ulo = a.ulo - b.uhi;
            early.uhi = a.uhi - b.ulo;
          end
        end
        OP_MUL: begin
        end
        OP_UDIV: begin
          early.stop = 1'b1;
          if (uzero) early.utop = 1'b1;
        end
        OP_SDIV: begin
          early.utop = 1'b1;
          if (szero) early.stop = 1'b1;
        end
        default: begin
          early.stop = 1'b1;
          early.utop = 1'b1;
        end
      endcase
    end
  end

  // stage 1: operands and early result
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= op;
      early1_r  <= early;
      smx1_r[0] <= mag(a.slo);
      smx1_r[1] <= mag(a.shi);
      smy1_r[0] <= mag(b.slo);
      smy1_r[1] <= mag(b.shi);
      sneg1_r   <= {is_neg(a.shi) ^ is_neg(b.shi), is_neg(a.shi) ^ is_neg(b.slo),
                    is_neg(a.slo) ^ is_neg(b.shi), is_neg(a.slo) ^ is_neg(b.slo)};
      ux1_r     <= {a.uhi, a.ulo};
      uy1_r     <= {b.uhi, b.ulo};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_dsel
    assign dx[i] = (op1_r == OP_SDIV) ? smx1_r[i>>1] : ux1_r[i>>1];
    assign dy[i] = (op1_r == OP_SDIV) ? smy1_r[i&1]  : uy1_r[i&1];
  end

  // stage 2: corner products
  always_ff @(posedge clk) begin
    if (en) begin
      op2_r    <= op1_r;
      early2_r <= early1_r;
      sneg2_r  <= sneg1_r;
      for (int i = 0; i < 4; i++) begin
        sp2_r[i] <= prod_t'(smx1_r[i>>1]) * prod_t'(smy1_r[i&1]);
        up2_r[i] <= prod_t'(ux1_r[i>>1]) * prod_t'(uy1_r[i&1]);
      end
    end
  end

  // stage 3: signs and overflow
  always_comb begin
    side_nxt       = '0;
    side_nxt.op    = op2_r;
    side_nxt.early = early2_r;
    side_nxt.sneg  = sneg2_r;
    for (int i = 0; i < 4; i++) begin
      side_nxt.sv[i] = sneg2_r[i] ? word_t'(-sp2_r[i][W-1:0]) : sp2_r[i][W-1:0];
      if (sp2_r[i] > prod_t'(lim(sneg2_r[i]))) side_nxt.sov = 1'b1;
      side_nxt.uv[i] = up2_r[i][W-1:0];
      if (up2_r[i][PW-1:W] != '0) side_nxt.uov = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
    end
  end

  assign side = side_r;

endmodule

### rtl/dia_back.sv
// ----------------------------------------------------------------------------
// dia_back
// Corner selection, min/max reduction and result formatting (2 stages).
// ----------------------------------------------------------------------------
module dia_back (
  input  logic                        clk,
  input  logic                        en,
  input  dia_pkg::side_t              side,
  input  logic [3:0][dia_pkg::W-1:0]  q,
  output logic [2:0]                  result_flags,
  output dia_pkg::word_t              result_signed_low,
  output dia_pkg::word_t              result_signed_high,
  output dia_pkg::word_t              result_unsigned_low,
  output dia_pkg::word_t              result_unsigned_high
);
  import dia_pkg::*;

  logic [3:0][W-1:0] cs, cu, cs_r, cu_r;
  logic              ovs, ovu, ovs_r, ovu_r, upd_s, upd_u, upd_s_r, upd_u_r;
  logic              late;
  ival_t             early_r, r;
  word_t             smin, smax, umin, umax;
  logic [2:0]        flags_nxt, flags_r;
  word_t             slo_r, shi_r, ulo_r, uhi_r;

  function automatic word_t pick_min(input word_t x, input word_t y, input logic sg);
    return (sg ? s_lt(y, x) : (y < x)) ? y : x;
  endfunction

  function automatic word_t pick_max(input word_t x, input word_t y, input logic sg);
    return (sg ? s_lt(x, y) : (x < y)) ? y : x;
  endfunction

  always_comb begin
    late  = !side.early.empty &&
            (side.op == OP_MUL || side.op == OP_UDIV || side.op == OP_SDIV);
    upd_s = late && (side.op == OP_MUL || side.op == OP_SDIV);
    upd_u = late && (side.op == OP_MUL || side.op == OP_UDIV);
    ovs   = 1'b0;
    ovu   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (side.op == OP_SDIV) begin
        cs[i] = side.sneg[i] ? word_t'(-q[i]) : q[i];
        if (q[i] > lim(side.sneg[i])) ovs = 1'b1;
      end else begin
        cs[i] = side.sv[i];
      end
      cu[i] = (side.op == OP_UDIV) ? q[i] : side.uv[i];
    end
    if (side.op == OP_MUL) begin
      ovs = side.sov;
      ovu = side.uov;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      early_r <= side.early;
      cs_r    <= cs;
      cu_r    <= cu;
      ovs_r   <= ovs;
      ovu_r   <= ovu;
      upd_s_r <= upd_s;
      upd_u_r <= upd_u;
    end
  end

  always_comb begin
    smin = pick_min(pick_min(cs_r[0], cs_r[1], 1'b1), pick_min(cs_r[2], cs_r[3], 1'b1), 1'b1);
    smax = pick_max(pick_max(cs_r[0], cs_r[1], 1'b1), pick_max(cs_r[2], cs_r[3], 1'b1), 1'b1);
    umin = pick_min(pick_min(cu_r[0], cu_r[1], 1'b0), pick_min(cu_r[2], cu_r[3], 1'b0), 1'b0);
    umax = pick_max(pick_max(cu_r[0], cu_r[1], 1'b0), pick_max(cu_r[2], cu_r[3], 1'b0), 1'b0);
    r = early_r;
    if (upd_s_r) begin
      r.stop = r.stop | ovs_r;
      r.slo  = smin;
      r.shi  = smax;
    end
    if (upd_u_r) begin
      r.utop = r.utop | ovu_r;
      r.ulo  = umin;
      r.uhi  = umax;
    end
    flags_nxt = '0;
    if (r.empty) begin
      flags_nxt[FLG_EMPTY] = 1'b1;
    end else begin
      flags_nxt[FLG_STOP] = r.stop;
      flags_nxt[FLG_UTOP] = r.utop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= flags_nxt;
      slo_r   <= (r.empty || r.stop) ? '0 : r.slo;
      shi_r   <= (r.empty || r.stop) ? '0 : r.shi;
      ulo_r   <= (r.empty || r.utop) ? '0 : r.ulo;
      uhi_r   <= (r.empty || r.utop) ? '0 : r.uhi;
    end
  end

  assign result_flags         = flags_r;
  assign result_signed_low    = slo_r;
  assign result_signed_high   = shi_r;
  assign result_unsigned_low  = ulo_r;
  assign result_unsigned_high = uhi_r;

endmodule

### rtl/dual_interval_alu.sv
// ----------------------------------------------------------------------------
// dual_interval_alu
// Interval arithmetic on signed/unsigned bound pairs: add, sub, mul, div, join, top.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle when not stalled; set by the one-bit-per-stage
// divider pipelines and the registered 32x32 corner multipliers.
// The whole pipeline halts while a finished result waits on out_tready.
// Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module dual_interval_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // a_flags, a_signed_low, a_signed_high, a_unsigned_low, a_unsigned_high,
  // b_flags, b_signed_low, b_signed_high, b_unsigned_low, b_unsigned_high
  input  logic [dia_pkg::IN_TDATA_W-1:0]      in_tdata,
  // opcode
  input  logic [dia_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_flags, result_signed_low, result_signed_high,
  // result_unsigned_low, result_unsigned_high
  output logic [dia_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import dia_pkg::*;

  logic              adv;
  logic [W+2:0]      vld_r;
  logic [3:0][W-1:0] dx, dy, q;
  side_t             side;
  side_t             dly_r [W-2];
  logic [2:0]        res_flags;
  word_t             res_slo, res_shi, res_ulo, res_uhi;

  assign adv       = !vld_r[W+2] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[W+1:0], in_tvalid};
    end
  end

  dia_front u_front (
    .clk             (clk),
    .en              (adv),
    .opcode          (in_tuser),
    .a_flags         (in_tdata[2:0]),
    .a_signed_low    (in_tdata[34:3]),
    .a_signed_high   (in_tdata[66:35]),
    .a_unsigned_low  (in_tdata[98:67]),
    .a_unsigned_high (in_tdata[130:99]),
    .b_flags         (in_tdata[133:131]),
    .b_signed_low    (in_tdata[165:134]),
    .b_signed_high   (in_tdata[197:166]),
    .b_unsigned_low  (in_tdata[229:198]),
    .b_unsigned_high (in_tdata[261:230]),
    .dx              (dx),
    .dy              (dy),
    .side            (side)
  );

  for (genvar i = 0; i < 4; i++) begin : g_div
    dia_div u_div (
      .clk (clk),
      .en  (adv),
      .num (dx[i]),
      .den (dy[i]),
      .quo (q[i])
    );
  end

  // align front-end sideband with divider output
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= side;
      for (int k = 1; k < W - 2; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  dia_back u_back (
    .clk                  (clk),
    .en                   (adv),
    .side                 (dly_r[W-3]),
    .q                    (q),
    .result_flags         (res_flags),
    .result_signed_low    (res_slo),
    .result_signed_high   (res_shi),
    .result_unsigned_low  (res_ulo),
    .result_unsigned_high (res_uhi)
  );

  assign out_tvalid = vld_r[W+2];
  assign out_tdata  = {5'b0, res_uhi, res_ulo, res_shi, res_slo, res_flags};

`ifndef ASSERT_OFF
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FLG_EMPTY] |-> out_tdata[2:1] == 2'b00 && out_tdata[130:3] == '0)
    else $error("empty result carries top flags or bounds");
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FLG_STOP] |-> out_tdata[66:3] == '0)
    else $error("signed top result has nonzero signed bounds");
  a_utop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FLG_UTOP] |-> out_tdata[130:67] == '0)
    else $error("unsigned top result has nonzero unsigned bounds");
`endif

endmodule
